[design/cte_pkg.sv]
// Shared constants, codes and types of the capability table engine.
package cte_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int DEPTH_W = 4;
  localparam int RBIT_W = 6;

  localparam logic [63:0] GEN_SEED = 64'hDEAD_BEEF_4242_4242;

  localparam logic REG_GRANT_BIT = 1'b0;
  localparam logic REG_INIT_DEPTH = 1'b1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_GRANT = 2'd1,
    OP_REVOKE = 2'd2,
    OP_VALIDATE = 2'd3
  } opcode_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOTOKEN = 3'd1;
  localparam logic [2:0] ST_REVOKED = 3'd2;
  localparam logic [2:0] ST_PERM = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic tok_we;
    logic rights_we;
    logic meta_we;
    logic depth_we;
    logic rev_we;
    logic mark_we;
  } tbl_wr_t;

endpackage

[design/cte_gen.sv]
// Xorshift token generator that advances once per appended entry.
module cte_gen
  import cte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  output logic [63:0] token_next
);

  logic [63:0] gen_state;
  logic [63:0] s1;
  logic [63:0] s2;

  assign s1 = gen_state ^ (gen_state << 13);
  assign s2 = s1 ^ (s1 >> 7);
  assign token_next = s2 ^ (s2 << 17);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= GEN_SEED;
    end else if (advance) begin
      gen_state <= token_next;
    end
  end

endmodule

[design/cte_table.sv]
// Capability table memories with one shared address and registered read data.
module cte_table
  import cte_pkg::*;
(
  input  logic               clk,
  input  logic [IDX_W-1:0]   addr,
  input  tbl_wr_t            wr,
  input  logic [63:0]        wtok,
  input  logic [63:0]        wrights,
  input  logic               whasp,
  input  logic [IDX_W-1:0]   wpidx,
  input  logic [DEPTH_W-1:0] wdepth,
  input  logic               wrev,
  input  logic               wmark,
  output logic [63:0]        rd_tok,
  output logic [63:0]        rd_rights,
  output logic               rd_hasp,
  output logic [IDX_W-1:0]   rd_pidx,
  output logic [DEPTH_W-1:0] rd_depth,
  output logic               rd_rev,
  output logic               rd_mark
);

  logic [63:0]        tok_mem    [TABLE_ENTRIES];
  logic [63:0]        rights_mem [TABLE_ENTRIES];
  logic [IDX_W:0]     meta_mem   [TABLE_ENTRIES];
  logic [DEPTH_W-1:0] depth_mem  [TABLE_ENTRIES];
  logic               rev_mem    [TABLE_ENTRIES];
  logic               mark_mem   [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.tok_we) tok_mem[addr] <= wtok;
    if (wr.rights_we) rights_mem[addr] <= wrights;
    if (wr.meta_we) meta_mem[addr] <= {whasp, wpidx};
    if (wr.depth_we) depth_mem[addr] <= wdepth;
    if (wr.rev_we) rev_mem[addr] <= wrev;
    if (wr.mark_we) mark_mem[addr] <= wmark;
    rd_tok <= tok_mem[addr];
    rd_rights <= rights_mem[addr];
    {rd_hasp, rd_pidx} <= meta_mem[addr];
    rd_depth <= depth_mem[addr];
    rd_rev <= rev_mem[addr];
    rd_mark <= mark_mem[addr];
  end

endmodule

[design/capability_table_engine_unit.sv]
// Top level of the capability table engine: sequencer, registers and ports.
//
// Items arrive on the s_ channel and one result per item leaves on the m_
// channel; a transfer happens when tvalid and tready are both high.
// The config channel writes grant_right_bit (index 0) and initial_depth
// (index 1) and is always ready; write it only while the block is idle.
// One item is worked on at a time and s_tready is high only when idle.
// Every operation except create walks the table from entry 0 through a
// single memory read port, with a read state (S_SRD) and a compare state
// (S_SCMP) per entry, until the token is found or no entries are left;
// an empty table is not walked. Create appends in S_APPEND with no walk;
// grant appends in S_APPEND after the hit. Revoke then walks all later
// entries through S_RVRD, S_RVPM and S_RVWR. Reset empties the table,
// reseeds the token generator and loads the register defaults; no clearing
// pass is needed. A finished result is held in an output register until the
// receiver takes it; the next item is accepted meanwhile and waits to finish.
module capability_table_engine_unit
  import cte_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,   // opcode[1:0], cap_token[65:2], rights_value[129:66], zeros
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [71:0]   m_tdata,   // status[2:0], new_token[66:3], zeros
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [5:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRD, S_SCMP, S_RVRD, S_RVPM, S_RVWR, S_APPEND, S_FIN
  } state_t;

  state_t state;
  opcode_t op;
  logic [63:0] tok;
  logic [63:0] rv;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] root;
  logic [IDX_W-1:0] pidx_q;
  logic hasp_q;
  logic [2:0] res_status;
  logic [63:0] res_token;
  logic [2:0] out_status;
  logic [63:0] out_token;
  logic out_valid;
  logic [63:0] ch_rights;
  logic [DEPTH_W-1:0] ch_depth;
  logic ch_hasp;
  logic [IDX_W-1:0] ch_pidx;
  logic [RBIT_W-1:0] grant_bit;
  logic [DEPTH_W-1:0] init_depth;

  logic [IDX_W-1:0] addr;
  tbl_wr_t wr;
  logic wmark;
  logic [63:0] rd_tok;
  logic [63:0] rd_rights;
  logic rd_hasp;
  logic [IDX_W-1:0] rd_pidx;
  logic [DEPTH_W-1:0] rd_depth;
  logic rd_rev;
  logic rd_mark;
  logic [63:0] gen_token;
  logic advance;
  logic hit;
  logic marked;
  logic [CNT_W-1:0] idx_inc;

  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid = out_valid;
  assign m_tdata = {5'd0, out_token, out_status};
  assign hit = (rd_tok == tok);
  assign marked = hasp_q && (pidx_q >= root) && rd_mark;
  assign idx_inc = idx + CNT_W'(1);
  assign advance = (state == S_APPEND);

  cte_gen u_gen (
    .clk(clk), .rst(rst), .advance(advance), .token_next(gen_token)
  );

  cte_table u_table (
    .clk(clk), .addr(addr), .wr(wr), .wtok(gen_token), .wrights(ch_rights),
    .whasp(ch_hasp), .wpidx(ch_pidx), .wdepth(ch_depth), .wrev(1'b0 | !advance),
    .wmark(wmark), .rd_tok(rd_tok), .rd_rights(rd_rights), .rd_hasp(rd_hasp),
    .rd_pidx(rd_pidx), .rd_depth(rd_depth), .rd_rev(rd_rev), .rd_mark(rd_mark)
  );

  always_comb begin
    addr = idx[IDX_W-1:0];
    wr = '0;
    wmark = 1'b1;
    unique case (state)
      S_SCMP: begin
        if (hit && op == OP_REVOKE) begin
          wr.rev_we = 1'b1;
          wr.mark_we = 1'b1;
        end
      end
      S_RVPM: addr = rd_pidx;
      S_RVWR: begin
        wr.mark_we = 1'b1;
        wmark = marked;
        wr.rev_we = marked;
      end
      S_APPEND: begin
        addr = cnt[IDX_W-1:0];
        wr.tok_we = 1'b1;
        wr.rights_we = 1'b1;
        wr.meta_we = 1'b1;
        wr.depth_we = 1'b1;
        wr.rev_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
      grant_bit <= '0;
      init_depth <= DEPTH_W'(8);
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_GRANT_BIT) grant_bit <= cfg_data;
        else if (cfg_index == REG_INIT_DEPTH) init_depth <= cfg_data[DEPTH_W-1:0];
      end
      if (out_valid && m_tready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= opcode_t'(s_tdata[1:0]);
            tok <= s_tdata[65:2];
            rv <= s_tdata[129:66];
            idx <= '0;
            res_token <= '0;
            if (opcode_t'(s_tdata[1:0]) == OP_CREATE) begin
              if (cnt == CNT_W'(TABLE_ENTRIES)) begin
                res_status <= ST_FULL;
                state <= S_FIN;
              end else begin
                ch_rights <= s_tdata[129:66];
                ch_depth <= init_depth;
                ch_hasp <= 1'b0;
                ch_pidx <= '0;
                state <= S_APPEND;
              end
            end else if (cnt == '0) begin
              res_status <= ST_NOTOKEN;
              state <= S_FIN;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (hit) begin
            res_status <= ST_OK;
            root <= idx[IDX_W-1:0];
            priority if (op == OP_REVOKE) begin
              idx <= idx_inc;
              state <= (idx_inc == cnt) ? S_FIN : S_RVRD;
            end else if (rd_rev) begin
              res_status <= ST_REVOKED;
              state <= S_FIN;
            end else if (op == OP_VALIDATE) begin
              if ((rd_rights & rv) != rv) res_status <= ST_PERM;
              state <= S_FIN;
            end else if (!rd_rights[grant_bit] || rd_depth == '0) begin
              res_status <= ST_PERM;
              state <= S_FIN;
            end else if (cnt == CNT_W'(TABLE_ENTRIES)) begin
              res_status <= ST_FULL;
              state <= S_FIN;
            end else begin
              ch_rights <= rd_rights & rv;
              ch_depth <= rd_depth - DEPTH_W'(1);
              ch_hasp <= 1'b1;
              ch_pidx <= idx[IDX_W-1:0];
              state <= S_APPEND;
            end
          end else begin
            idx <= idx_inc;
            if (idx_inc == cnt) begin
              res_status <= ST_NOTOKEN;
              state <= S_FIN;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_RVRD: state <= S_RVPM;
        S_RVPM: begin
          hasp_q <= rd_hasp;
          pidx_q <= rd_pidx;
          state <= S_RVWR;
        end
        S_RVWR: begin
          idx <= idx_inc;
          state <= (idx_inc == cnt) ? S_FIN : S_RVRD;
        end
        S_APPEND: begin
          cnt <= cnt + CNT_W'(1);
          res_status <= ST_OK;
          res_token <= gen_token;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_status <= res_status;
            out_token <= res_token;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (cnt != $past(cnt)) |-> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ST_FULL))
    else $error("status code out of range");

  a_token_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[66:3] == '0))
    else $error("token reported with failing status");

endmodule

[dv/cte_checker.sv]
// Checker that predicts and compares every result of the capability table engine.
module cte_checker
  import cte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [5:0]   cfg_data,
  output int           errors,
  output int           pending
);

  logic [63:0] tok_tbl [TABLE_ENTRIES];
  logic [63:0] rights_tbl [TABLE_ENTRIES];
  logic [63:0] parent_tbl [TABLE_ENTRIES];
  logic [DEPTH_W-1:0] depth_tbl [TABLE_ENTRIES];
  logic revoked_tbl [TABLE_ENTRIES];
  int count;
  logic [63:0] gen;
  logic [RBIT_W-1:0] grant_bit;
  logic [DEPTH_W-1:0] root_depth;

  logic [2:0] status_q [$];
  logic [63:0] token_q [$];

  assign pending = status_q.size();

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic int find(logic [63:0] tok);
    for (int i = 0; i < count; i++)
      if (tok_tbl[i] == tok) return i;
    return -1;
  endfunction

  function automatic logic [63:0] append(logic [63:0] r, logic [63:0] par,
                                         logic [DEPTH_W-1:0] d);
    logic [63:0] s;
    s = gen;
    s ^= s << 13;
    s ^= s >> 7;
    s ^= s << 17;
    gen = s;
    tok_tbl[count] = s;
    rights_tbl[count] = r;
    parent_tbl[count] = par;
    depth_tbl[count] = d;
    revoked_tbl[count] = 1'b0;
    count++;
    return s;
  endfunction

  function automatic void revoke_subtree(int root);
    bit marked [TABLE_ENTRIES];
    int p;
    revoked_tbl[root] = 1'b1;
    marked[root] = 1'b1;
    for (int i = root + 1; i < count; i++) begin
      p = find(parent_tbl[i]);
      if (p >= 0 && marked[p]) begin
        marked[i] = 1'b1;
        revoked_tbl[i] = 1'b1;
      end
    end
  endfunction

  function automatic void predict(opcode_t op, logic [63:0] tok, logic [63:0] rv,
                                  output logic [2:0] st, output logic [63:0] made);
    int e;
    st = ST_OK;
    made = '0;
    if (op == OP_CREATE) begin
      if (count >= TABLE_ENTRIES) st = ST_FULL;
      else made = append(rv, '0, root_depth);
    end else begin
      e = find(tok);
      if (e < 0) st = ST_NOTOKEN;
      else if (op == OP_REVOKE) revoke_subtree(e);
      else if (revoked_tbl[e]) st = ST_REVOKED;
      else if (op == OP_VALIDATE) begin
        if ((rights_tbl[e] & rv) != rv) st = ST_PERM;
      end else if (!rights_tbl[e][grant_bit] || depth_tbl[e] == 0) st = ST_PERM;
      else if (count >= TABLE_ENTRIES) st = ST_FULL;
      else made = append(rights_tbl[e] & rv, tok, depth_tbl[e] - 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    logic [2:0] st;
    logic [63:0] made;
    if (rst) begin
      count = 0;
      gen = GEN_SEED;
      grant_bit = '0;
      root_depth = 4'd8;
      status_q.delete();
      token_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRANT_BIT) grant_bit = cfg_data;
        else root_depth = cfg_data[DEPTH_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        predict(opcode_t'(s_tdata[1:0]), s_tdata[65:2], s_tdata[129:66], st, made);
        status_q.push_back(st);
        token_q.push_back(made);
      end
      if (m_tvalid && m_tready) begin
        if (status_q.size() == 0) begin
          report("unexpected result", m_tdata[66:3], '0);
        end else begin
          st = status_q.pop_front();
          made = token_q.pop_front();
          if (m_tdata[2:0] != st) report("status", 64'(m_tdata[2:0]), 64'(st));
          if (m_tdata[66:3] != made) report("new_token", m_tdata[66:3], made);
        end
      end
    end
  end

endmodule

[dv/tb_top.sv]
// Testbench top: clock, reset, stimulus, idling and verdict for the engine.
module tb_top;
  import cte_pkg::*;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [135:0] s_tdata;
  logic [71:0] m_tdata;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [5:0] cfg_data;
  int errors, pending;
  int sent, taken;
  bit calm, held;
  logic [63:0] known [$];

  capability_table_engine_unit u_top (.*);
  cte_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL capability_table_engine_unit");
    $finish;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) begin
      taken++;
      if (m_tdata[2:0] == ST_OK && m_tdata[66:3] != 0) known.push_back(m_tdata[66:3]);
    end

  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && taken >= 150) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_tready <= calm || $urandom_range(99) >= 22;
      @(posedge clk);
    end
  end

  task automatic write_reg(logic idx, logic [5:0] val);
    wait (pending == 0);
    repeat (3200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(opcode_t op, logic [63:0] tok, logic [63:0] rv);
    if (!calm && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, rv, tok, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_wait(opcode_t op, logic [63:0] tok, logic [63:0] rv);
    send(op, tok, rv);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_token();
    int r;
    r = $urandom_range(99);
    if (known.size() > 0 && r < 85) return known[$urandom_range(known.size() - 1)];
    if (r < 92) return 64'd0;
    return rand64();
  endfunction

  task automatic random_phase(int n, logic [5:0] gbit);
    int r;
    logic [63:0] rv;
    for (int i = 0; i < n; i++) begin
      calm = sent >= 300 && sent < 360;
      r = $urandom_range(99);
      rv = rand64();
      if (r < 30) begin
        if ($urandom_range(3) != 0) rv[gbit] = 1'b1;
        send(OP_CREATE, rand64(), rv);
      end else if (r < 60) begin
        if ($urandom_range(3) != 0) rv[gbit] = 1'b1;
        send(OP_GRANT, pick_token(), rv);
      end else if (r < 68) begin
        send(OP_REVOKE, pick_token(), rv);
      end else begin
        if ($urandom_range(1)) rv = rv & rand64() & rand64();
        send(OP_VALIDATE, pick_token(), rv);
      end
    end
    calm = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0] root, kid, grand;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GRANT_BIT;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_GRANT_BIT, 6'd0);
    write_reg(REG_INIT_DEPTH, 6'd2);
    send_wait(OP_CREATE, '0, '1);
    root = known[$];
    send_wait(OP_GRANT, root, 64'hFFFF_0000_FFFF_00FF);
    kid = known[$];
    send_wait(OP_GRANT, kid, 64'h0F0F_0F0F_0F0F_0F0F);
    grand = known[$];
    send_wait(OP_GRANT, grand, '1);
    send_wait(OP_VALIDATE, kid, 64'hFFFF_0000_FFFF_00FF);
    send_wait(OP_VALIDATE, kid, 64'h8000_0000_0000_0000);
    send_wait(OP_VALIDATE, 64'd0, '0);
    send_wait(OP_GRANT, 64'd0, '1);
    send_wait(OP_REVOKE, 64'd0, '0);
    send_wait(OP_REVOKE, '1, '1);
    send_wait(OP_CREATE, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_wait(OP_GRANT, known[$], '1);
    send_wait(OP_VALIDATE, known[$], '0);
    send_wait(OP_REVOKE, root, '0);
    send_wait(OP_VALIDATE, grand, '0);
    send_wait(OP_GRANT, kid, '1);
    send_wait(OP_REVOKE, root, '0);
    send_wait(OP_VALIDATE, root, '0);

    write_reg(REG_GRANT_BIT, 6'd63);
    write_reg(REG_INIT_DEPTH, 6'd15);
    random_phase(200, 6'd63);
    write_reg(REG_GRANT_BIT, 6'($urandom_range(1, 62)));
    write_reg(REG_INIT_DEPTH, 6'd0);
    random_phase(60, 6'd0);
    write_reg(REG_GRANT_BIT, 6'd5);
    write_reg(REG_INIT_DEPTH, 6'd1);
    random_phase(150, 6'd5);
    write_reg(REG_GRANT_BIT, 6'd0);
    write_reg(REG_INIT_DEPTH, 6'($urandom_range(2, 14)));
    random_phase(150, 6'd0);

    wait (pending == 0);
    send(OP_GRANT, known[known.size() - 1], '1);
    send(OP_VALIDATE, known[0], '0);
    send(OP_REVOKE, known[0], '0);
    s_tvalid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS capability_table_engine_unit");
    else $display("FAIL capability_table_engine_unit");
    $finish;
  end

endmodule
